// ----- src/aes_key_expansion_macros.svh -----
// assertion macros for the aes key expansion block
`ifndef AES_KEY_EXPANSION_MACROS_SVH
`define AES_KEY_EXPANSION_MACROS_SVH

`ifndef SYNTHESIS
`define AKE_ASSERT(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define AKE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AKE_ASSERT(label, clk, rst_n, expr)
`define AKE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/aesk_pkg.sv -----
// constants, s-box and helper functions for the aes key expansion
`timescale 1ns / 1ps
`default_nettype none
package aesk_pkg;

	localparam logic [1:0] MODE_128 = 2'd0;
	localparam logic [1:0] MODE_192 = 2'd1;
	localparam logic [1:0] MODE_256 = 2'd2;

	localparam logic [7:0] RCON_FIRST = 8'h01;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [31:0] rot_word(input logic [31:0] w);
		return {w[7:0], w[31:8]};
	endfunction

	// multiply by x in gf(2^8)
	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

endpackage
`default_nettype wire

// ----- src/aes_key_expansion.sv -----
// aes key expansion top level: 128/192/256-bit keys, one schedule word per cycle unless the output stalls
// Takes one key plus a 128-bit IV per input beat and returns round keys 0..Nr
// (Nr = 10, 12 or 14 for key_length_mode 0, 1, 2; mode 3 acts as 2) in order,
// with last_key set on round key Nr and the IV xored into round key 0 only.
// A single s-box word unit builds one 32-bit schedule word per cycle unless the
// output side stalls; each key is taken in, then expanded into 4*(Nr+1) words.
// in_ready is low while a key is being expanded. The output register lets the
// final round key wait while the next key is taken in.
`timescale 1ns / 1ps
`default_nettype none
`include "aes_key_expansion_macros.svh"
module aes_key_expansion (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [1:0]  cfg_write_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] key_w0,
	input  wire logic [63:0] key_w1,
	input  wire logic [63:0] key_w2,
	input  wire logic [63:0] key_w3,
	input  wire logic [63:0] iv_lo,
	input  wire logic [63:0] iv_hi,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       round_index,
	output logic [63:0]      round_key_lo,
	output logic [63:0]      round_key_hi,
	output logic             last_key
);

	typedef enum logic {ST_IDLE, ST_EXPAND} state_t;

	state_t      state_q;
	logic [1:0]  key_length_mode_q;
	logic [1:0]  mode_q;
	logic [5:0]  word_cnt_q;
	logic [2:0]  pos_q;
	logic [7:0]  rcon_q;
	logic [31:0] key_q [8];
	logic [31:0] win_q [8];
	logic [31:0] acc_q [3];
	logic [63:0] iv_lo_q;
	logic [63:0] iv_hi_q;

	logic [3:0]  nk;
	logic [3:0]  nr;
	logic [31:0] w_prev;
	logic [31:0] w_back;
	logic [31:0] sub_in;
	logic [31:0] sub_out;
	logic [31:0] temp;
	logic [31:0] new_word;
	logic        is_key_word;
	logic        rot_pos;
	logic        sub_pos;
	logic        group_end;
	logic        last_word;
	logic        step_en;
	logic        emit_key;
	logic        accept;
	logic [63:0] rk_lo;
	logic [63:0] rk_hi;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		case (mode_q)
			aesk_pkg::MODE_128: begin
				nk = 4'd4;
				w_back = win_q[4];
			end
			aesk_pkg::MODE_192: begin
				nk = 4'd6;
				w_back = win_q[2];
			end
			default: begin
				nk = 4'd8;
				w_back = win_q[0];
			end
		endcase
	end

	assign nr = nk + 4'd6;
	assign w_prev = win_q[7];
	assign is_key_word = (word_cnt_q < {2'b00, nk});
	assign rot_pos = (pos_q == 3'd0);
	assign sub_pos = (nk == 4'd8) && (pos_q == 3'd4);

	// the one shared s-box word unit
	assign sub_in = rot_pos ? aesk_pkg::rot_word(w_prev) : w_prev;
	assign sub_out = aesk_pkg::sub_word(sub_in);

	always_comb begin
		if (rot_pos) begin
			temp = sub_out ^ {24'h000000, rcon_q};
		end else if (sub_pos) begin
			temp = sub_out;
		end else begin
			temp = w_prev;
		end
		new_word = is_key_word ? key_q[0] : (w_back ^ temp);
	end

	assign group_end = (word_cnt_q[1:0] == 2'd3);
	assign last_word = group_end && (word_cnt_q[5:2] == nr);
	assign step_en = (state_q == ST_EXPAND) && !(group_end && out_valid && !out_ready);
	assign emit_key = step_en && group_end;

	always_comb begin
		rk_lo = {acc_q[1], acc_q[0]};
		rk_hi = {new_word, acc_q[2]};
		if (word_cnt_q[5:2] == 4'd0) begin
			rk_lo = rk_lo ^ iv_lo_q;
			rk_hi = rk_hi ^ iv_hi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			key_length_mode_q <= aesk_pkg::MODE_128;
			mode_q <= aesk_pkg::MODE_128;
			word_cnt_q <= '0;
			pos_q <= '0;
			rcon_q <= aesk_pkg::RCON_FIRST;
			out_valid <= 1'b0;
			round_index <= '0;
			round_key_lo <= '0;
			round_key_hi <= '0;
			last_key <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				key_length_mode_q <= cfg_write_data;
			end
			if (emit_key) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q <= (key_length_mode_q > aesk_pkg::MODE_256) ? aesk_pkg::MODE_256
							: key_length_mode_q;
						word_cnt_q <= '0;
						pos_q <= '0;
						rcon_q <= aesk_pkg::RCON_FIRST;
						state_q <= ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (step_en) begin
						word_cnt_q <= word_cnt_q + 6'd1;
						pos_q <= ({1'b0, pos_q} == nk - 4'd1) ? 3'd0 : pos_q + 3'd1;
						if (!is_key_word && rot_pos) begin
							rcon_q <= aesk_pkg::xtime(rcon_q);
						end
						if (group_end) begin
							round_index <= word_cnt_q[5:2];
							round_key_lo <= rk_lo;
							round_key_hi <= rk_hi;
							last_key <= last_word;
						end
						if (last_word) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// key words, sliding schedule window and round key collector
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q[0] <= key_w0[31:0];
			key_q[1] <= key_w0[63:32];
			key_q[2] <= key_w1[31:0];
			key_q[3] <= key_w1[63:32];
			key_q[4] <= key_w2[31:0];
			key_q[5] <= key_w2[63:32];
			key_q[6] <= key_w3[31:0];
			key_q[7] <= key_w3[63:32];
			iv_lo_q <= iv_lo;
			iv_hi_q <= iv_hi;
		end else if (step_en) begin
			for (int k = 0; k < 7; k++) begin
				key_q[k] <= key_q[k + 1];
			end
			key_q[7] <= key_q[7];
		end
		if (step_en) begin
			for (int k = 0; k < 7; k++) begin
				win_q[k] <= win_q[k + 1];
			end
			win_q[7] <= new_word;
			if (!group_end) begin
				acc_q[word_cnt_q[1:0]] <= new_word;
			end
		end
	end

	`AKE_ASSERT(a_word_cnt_range, clk, arst_n, state_q != ST_EXPAND || word_cnt_q <= 6'd59)
	`AKE_ASSERT_NEXT(a_start_clean, clk, arst_n, accept, (word_cnt_q == 6'd0) && (state_q == ST_EXPAND))
	`AKE_ASSERT(a_last_index, clk, arst_n, !(out_valid && last_key) || round_index == 4'd10 || round_index == 4'd12 || round_index == 4'd14)

endmodule
`default_nettype wire

// ----- tb/tb_aes_key_expansion.sv -----
// self-checking testbench for the aes key expansion block: directed and random keys, all key sizes
`timescale 1ns / 1ps
module tb_aes_key_expansion;

	// code 3 has no size of its own and must behave as the 256-bit schedule
	localparam logic [1:0] MODE_ALIAS_256 = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;
	localparam int RAND_PHASES = 6;
	localparam int KEYS_PER_PHASE = 14;

	typedef struct {
		logic [63:0] k0, k1, k2, k3, ivl, ivh;
		int unsigned gap;
		bit          drain;
	} key_beat_t;

	typedef struct packed {
		logic [3:0]  idx;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        last;
	} round_key_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_write_data = aesk_pkg::MODE_128;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] key_w0 = '0;
	logic [63:0] key_w1 = '0;
	logic [63:0] key_w2 = '0;
	logic [63:0] key_w3 = '0;
	logic [63:0] iv_lo = '0;
	logic [63:0] iv_hi = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  round_index;
	logic [63:0] round_key_lo;
	logic [63:0] round_key_hi;
	logic        last_key;

	logic [7:0]  sbox_tbl [256];
	logic [7:0]  rcon_tbl [10];
	logic [1:0]  cur_mode = aesk_pkg::MODE_128;

	key_beat_t   keys_to_send [$];
	round_key_t  round_keys_due [$];

	int unsigned sent_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned out_cnt = 0;
	int unsigned rx_seen = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned hold_left = 0;
	int unsigned stall_req = 0;
	int unsigned stall_seen = 0;
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	int          n_err = 0;
	int          idle_cycles = 0;

	aes_key_expansion i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_w0         (key_w0),
		.key_w1         (key_w1),
		.key_w2         (key_w2),
		.key_w3         (key_w3),
		.iv_lo          (iv_lo),
		.iv_hi          (iv_hi),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.round_index    (round_index),
		.round_key_lo   (round_key_lo),
		.round_key_hi   (round_key_hi),
		.last_key       (last_key)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = '0;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p = p ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// s-box from the field inverse and the affine map, rcon by doubling
	task automatic build_tables();
		logic [7:0] inv;
		logic [7:0] r;
		for (int b = 0; b < 256; b++) begin
			inv = '0;
			for (int x = 1; x < 256; x++)
				if (gf_mul(8'(b), 8'(x)) == 8'h01)
					inv = 8'(x);
			sbox_tbl[b] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
				^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
		end
		r = 8'h01;
		for (int k = 0; k < 10; k++) begin
			rcon_tbl[k] = r;
			r = gf_mul(r, 8'h02);
		end
	endtask

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {sbox_tbl[w[31:24]], sbox_tbl[w[23:16]], sbox_tbl[w[15:8]], sbox_tbl[w[7:0]]};
	endfunction

	// full schedule for one key, queues round keys 0..nr
	task automatic expand_schedule(input key_beat_t kb, input logic [1:0] mode);
		logic [31:0] w [60];
		logic [31:0] t;
		int nk;
		int nr;
		int total;
		int pos;
		round_key_t rk;
		nk = (mode == aesk_pkg::MODE_128) ? 4 : (mode == aesk_pkg::MODE_192) ? 6 : 8;
		nr = nk + 6;
		total = 4 * (nr + 1);
		for (int i = 0; i < 60; i++)
			w[i] = '0;
		w[0] = kb.k0[31:0];
		w[1] = kb.k0[63:32];
		w[2] = kb.k1[31:0];
		w[3] = kb.k1[63:32];
		w[4] = kb.k2[31:0];
		w[5] = kb.k2[63:32];
		w[6] = kb.k3[31:0];
		w[7] = kb.k3[63:32];
		for (int i = nk; i < total; i++) begin
			t = w[i - 1];
			pos = i % nk;
			if (pos == 0)
				t = sbox_word({t[7:0], t[31:8]}) ^ {24'h0, rcon_tbl[i / nk - 1]};
			else if (nk == 8 && pos == 4)
				t = sbox_word(t);
			w[i] = w[i - nk] ^ t;
		end
		for (int r = 0; r <= nr; r++) begin
			rk.idx = 4'(r);
			rk.lo = {w[4 * r + 1], w[4 * r]};
			rk.hi = {w[4 * r + 3], w[4 * r + 2]};
			if (r == 0) begin
				rk.lo = rk.lo ^ kb.ivl;
				rk.hi = rk.hi ^ kb.ivh;
			end
			rk.last = (r == nr);
			round_keys_due.push_back(rk);
		end
	endtask

	task automatic flag_error(input string msg);
		n_err++;
		if (n_err <= 10)
			$display("%s", msg);
	endtask

	function automatic logic [63:0] rand_field();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_key(input logic [63:0] k0, input logic [63:0] k1, input logic [63:0] k2,
			input logic [63:0] k3, input logic [63:0] ivl, input logic [63:0] ivh,
			input bit drain);
		key_beat_t kb;
		kb.k0 = k0;
		kb.k1 = k1;
		kb.k2 = k2;
		kb.k3 = k3;
		kb.ivl = ivl;
		kb.ivh = ivh;
		kb.gap = tx_quiet ? 0 : $urandom_range(0, 9);
		kb.drain = drain;
		keys_to_send.push_back(kb);
	endtask

	// checked at the rising edge, where the driver's counters have settled,
	// then returns at the next falling edge
	task automatic wait_idle();
		do
			@(posedge clk);
		while (keys_to_send.size() != 0 || taken_cnt != sent_cnt || round_keys_due.size() != 0);
		@(negedge clk);
	endtask

	// called only when idle, right after wait_idle
	task automatic set_mode(input logic [1:0] m);
		cfg_write_en <= 1'b1;
		cfg_write_data <= m;
		cur_mode = m;
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	always @(negedge clk) begin : drive_keys
		key_beat_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && taken_cnt != sent_cnt) begin
			// beat still waiting for in_ready
		end else if (keys_to_send.size() == 0
				|| (keys_to_send[0].drain && round_keys_due.size() != 0)) begin
			in_valid <= 1'b0;
		end else if (tx_wait < keys_to_send[0].gap) begin
			in_valid <= 1'b0;
			tx_wait <= tx_wait + 1;
		end else begin
			nb = keys_to_send.pop_front();
			key_w0 <= nb.k0;
			key_w1 <= nb.k1;
			key_w2 <= nb.k2;
			key_w3 <= nb.k3;
			iv_lo <= nb.ivl;
			iv_hi <= nb.ivh;
			in_valid <= 1'b1;
			sent_cnt <= sent_cnt + 1;
			tx_wait <= 0;
		end
	end

	always @(negedge clk) begin : drive_ready
		int unsigned g;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_req != stall_seen) begin
			stall_seen <= stall_req;
			hold_left <= HOLD_CYCLES;
			rx_seen <= out_cnt;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rx_seen <= out_cnt;
			out_ready <= (hold_left == 1);
		end else if (out_cnt != rx_seen) begin
			rx_seen <= out_cnt;
			g = rx_quiet ? 0 : $urandom_range(0, 9);
			rx_wait <= g;
			out_ready <= (g == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			out_ready <= (rx_wait == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_and_predict
		round_key_t got;
		round_key_t want;
		key_beat_t kb;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				out_cnt <= out_cnt + 1;
				got.idx = round_index;
				got.lo = round_key_lo;
				got.hi = round_key_hi;
				got.last = last_key;
				if (round_keys_due.size() == 0) begin
					flag_error($sformatf("round key beat with none due: idx %0d lo %h hi %h last %b",
						got.idx, got.lo, got.hi, got.last));
				end else begin
					want = round_keys_due.pop_front();
					if (got.idx !== want.idx || got.lo !== want.lo || got.hi !== want.hi
							|| got.last !== want.last)
						flag_error($sformatf({"round key mismatch: expected idx %0d lo %h hi %h ",
							"last %b, got idx %0d lo %h hi %h last %b"},
							want.idx, want.lo, want.hi, want.last,
							got.idx, got.lo, got.hi, got.last));
				end
			end
			if (in_valid && in_ready) begin
				taken_cnt <= taken_cnt + 1;
				kb.k0 = key_w0;
				kb.k1 = key_w1;
				kb.k2 = key_w2;
				kb.k3 = key_w3;
				kb.ivl = iv_lo;
				kb.ivh = iv_hi;
				kb.gap = 0;
				kb.drain = 1'b0;
				expand_schedule(kb, cur_mode);
			end
		end
	end

	// counts cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		logic [1:0] m;
		build_tables();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register: 128-bit keys, upper key words ignored
		push_key('0, '0, '0, '0, '0, '0, 1'b0);
		push_key('1, '1, '1, '1, '1, '1, 1'b0);
		push_key(64'ha6d2ae2816157e2b, 64'h3c4fcf098815f7ab, {$urandom, $urandom},
			{$urandom, $urandom}, '0, '0, 1'b0);
		push_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, '1, '0,
			64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
		push_key({$urandom, $urandom}, {$urandom, $urandom}, '0, '1, '1, '0, 1'b0);

		wait_idle();
		set_mode(aesk_pkg::MODE_192);
		push_key('0, '0, '0, '0, '0, '0, 1'b0);
		push_key('1, '1, '1, '1, '1, '1, 1'b0);
		push_key(64'h52640edaf7b0738e, 64'he57990802bf310c8, 64'h7b6b2c52d2eaf862,
			{$urandom, $urandom}, '0, '0, 1'b0);
		push_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, '1,
			{$urandom, $urandom}, {$urandom, $urandom}, 1'b0);

		wait_idle();
		set_mode(aesk_pkg::MODE_256);
		push_key('0, '0, '0, '0, '0, '0, 1'b0);
		push_key('1, '1, '1, '1, '1, '1, 1'b0);
		push_key(64'hbe71ca1510eb3d60, 64'h81777d85f0ae732b, 64'hd708613b072c351f,
			64'hf4df1409a310982d, '0, '0, 1'b0);
		push_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, '1, '1, 1'b0);

		wait_idle();
		set_mode(MODE_ALIAS_256);
		push_key('1, '1, '1, '1, '0, '0, 1'b0);
		push_key(64'hbe71ca1510eb3d60, 64'h81777d85f0ae732b, 64'hd708613b072c351f,
			64'hf4df1409a310982d, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
		push_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: m = aesk_pkg::MODE_256;
				1: m = aesk_pkg::MODE_128;
				2: m = aesk_pkg::MODE_192;
				3: m = MODE_ALIAS_256;
				default: m = 2'($urandom_range(0, 3));
			endcase
			set_mode(m);
			// first phase runs back to back with no idling on either side
			tx_quiet = (ph == 0);
			rx_quiet = (ph == 0);
			for (int n = 0; n < KEYS_PER_PHASE; n++)
				push_key(rand_field(), rand_field(), rand_field(), rand_field(),
					rand_field(), rand_field(), (ph == 2 && n == KEYS_PER_PHASE / 2));
			// long receiver stall while keys keep coming, so the input backs up
			if (ph == 1)
				stall_req++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (round_keys_due.size() != 0)
			flag_error($sformatf("%0d round keys never arrived", round_keys_due.size()));
		if (n_err == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/aesk_pkg.sv
src/aes_key_expansion.sv
tb/tb_aes_key_expansion.sv
